// ===== sv/scd_pkg.sv =====
// ----------------------------------------------------------------------------
// scd_pkg: shared types and constants for the sine/cosine pipeline
// Fixed-point formats, series length and the control bundle that travels with
// every item through the pipeline.
// ----------------------------------------------------------------------------
package scd_pkg;

  // Series length and angle format.
  localparam int LAST_TERM       = 20;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ANGLE_W         = 18;

  // Internal formats: series values carry 40 fraction bits.
  localparam int SER_FRAC = 40;
  localparam int OUT_FRAC = 30;
  localparam int OUT_W    = 32;
  localparam int MUL_W    = 56;
  localparam int HALF_W   = MUL_W / 2;
  localparam int Y2_W     = 46;
  localparam int SUM_W    = 58;

  // Opcode value that selects cosine.
  localparam logic OP_COSINE = 1'b1;

  // pi with 60 fraction bits, and pi/180 in Q0.60 rounded from it.
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] K60    = (PI_Q60 + 64'd90) / 64'd180;

  // Control and running sum that travel with one item.
  typedef struct packed {
    logic                    valid;
    logic                    cosine;
    logic                    neg;
    logic [Y2_W-1:0]         y2;
    logic signed [SUM_W-1:0] sum;
  } scd_ctl_t;

endpackage

// ===== sv/scd_mul.sv =====
// ----------------------------------------------------------------------------
// scd_mul: two-stage rounding multiplier
// Forms a*b from four 28x28 partial products, then rounds half up by 40 bits.
// ----------------------------------------------------------------------------
module scd_mul import scd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  scd_ctl_t         ctl_in,
  input  logic [MUL_W-1:0] a_in,
  input  logic [MUL_W-1:0] b_in,
  output scd_ctl_t         ctl_out,
  output logic [MUL_W-1:0] p_out
);

  scd_ctl_t            ctl1_r, ctl2_r;
  logic [MUL_W-1:0]    pp00_r, pp01_r, pp10_r, pp11_r;
  logic [2*MUL_W-1:0]  full;
  logic [MUL_W-1:0]    p_nxt, p_r;

  // First stage: partial products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl_in;
      pp00_r <= MUL_W'(a_in[HALF_W-1:0]) * MUL_W'(b_in[HALF_W-1:0]);
      pp01_r <= MUL_W'(a_in[HALF_W-1:0]) * MUL_W'(b_in[MUL_W-1:HALF_W]);
      pp10_r <= MUL_W'(a_in[MUL_W-1:HALF_W]) * MUL_W'(b_in[HALF_W-1:0]);
      pp11_r <= MUL_W'(a_in[MUL_W-1:HALF_W]) * MUL_W'(b_in[MUL_W-1:HALF_W]);
    end
  end

  // Second stage: combine partials and round.
  always_comb begin
    full = {pp11_r, pp00_r}
         + ({{MUL_W{1'b0}}, pp01_r} << HALF_W)
         + ({{MUL_W{1'b0}}, pp10_r} << HALF_W)
         + ((2*MUL_W)'(1) << (SER_FRAC - 1));
    p_nxt = full[SER_FRAC +: MUL_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else if (en) begin
      ctl2_r <= ctl1_r;
      p_r    <= p_nxt;
    end
  end

  assign ctl_out = ctl2_r;
  assign p_out   = p_r;

endmodule

// ===== sv/scd_term.sv =====
// ----------------------------------------------------------------------------
// scd_term: one Taylor series term
// Multiplies the previous term by y squared and by the term's reciprocal,
// then adds or subtracts the new term from the running sum.
// ----------------------------------------------------------------------------
module scd_term import scd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [MUL_W-1:0] rec_sin,
  input  logic [MUL_W-1:0] rec_cos,
  input  logic             sub,
  input  scd_ctl_t         ctl_in,
  input  logic [MUL_W-1:0] t_in,
  output scd_ctl_t         ctl_out,
  output logic [MUL_W-1:0] t_out
);

  scd_ctl_t         ctl_a, ctl_b, ctl_nxt, ctl_r;
  logic [MUL_W-1:0] p_a, p_b, rec, t_r;

  // Previous term times y squared.
  scd_mul u_mul_y2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .ctl_in(ctl_in), .a_in(t_in), .b_in(MUL_W'(ctl_in.y2)),
    .ctl_out(ctl_a), .p_out(p_a)
  );

  // The reciprocal depends on which series this item runs.
  assign rec = (ctl_a.cosine == OP_COSINE) ? rec_cos : rec_sin;

  scd_mul u_mul_rec (
    .clk(clk), .rst_n(rst_n), .en(en),
    .ctl_in(ctl_a), .a_in(p_a), .b_in(rec),
    .ctl_out(ctl_b), .p_out(p_b)
  );

  // Accumulate the new term with alternating sign.
  always_comb begin
    ctl_nxt = ctl_b;
    if (sub) begin
      ctl_nxt.sum = ctl_b.sum - $signed(SUM_W'(p_b));
    end else begin
      ctl_nxt.sum = ctl_b.sum + $signed(SUM_W'(p_b));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
      t_r   <= p_b;
    end
  end

  assign ctl_out = ctl_r;
  assign t_out   = t_r;

endmodule

// ===== sv/sine_cosine_degrees.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_degrees: pipelined sine or cosine of an angle in degrees
// Converts a Q10.8 angle to radians and sums a Taylor series, one term per
// five pipeline stages, producing a signed Q2.30 result.
// ----------------------------------------------------------------------------
//  Channel  Direction  tdata                      tuser
//  in_      slave      angle_degrees (18, signed) opcode (1)
//  out_     master     value (32, signed)         -
//
// One request is taken every cycle while no result waits on out_tready. Five
// stages do the radian conversion and y squared, five per term (two two-stage
// multipliers and the sum register), then the output register.
// Synchronous active-low reset clears all valid bits; nothing else is kept.
// The whole pipeline holds while a result waits on out_tready, so a stall
// neither drops nor repeats an item.
module sine_cosine_degrees import scd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [17:0] angle_degrees, [23:18] zero
  input  logic        in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] value
);

  localparam int          YSH   = ANGLE_FRAC_BITS + 20;
  localparam int          PP_W  = ANGLE_W + 30;
  localparam int          YF_W  = YSH + MUL_W;
  localparam logic [31:0] LIMIT = 32'(360) << ANGLE_FRAC_BITS;

  logic               en;
  logic [ANGLE_W-1:0] raw, mag;
  scd_ctl_t           ctl0_nxt, ctl0_r, ctl1_r, ctl2_nxt, ctl2_r, ctl3, ctl_t0;
  logic [ANGLE_W-1:0] mag0_r;
  logic [PP_W-1:0]    pplo_r, pphi_r;
  logic [YF_W-1:0]    yfull;
  logic [MUL_W-1:0]   y_r, y2_p, t0;
  scd_ctl_t           ctl_c [0:LAST_TERM];
  logic [MUL_W-1:0]   t_c   [0:LAST_TERM];
  logic               res_neg;
  logic [SUM_W-1:0]   q, om;
  logic [OUT_FRAC:0]  om_sat;
  logic [OUT_W-1:0]   out_tdata_nxt, out_tdata_r;
  logic               out_tvalid_r;

  // The pipeline moves whenever the output register is free or being taken.
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // Input stage: magnitude, sign and clamp to 360 degrees.
  always_comb begin
    raw = in_tdata[ANGLE_W-1:0];
    mag = raw[ANGLE_W-1] ? (ANGLE_W'(0) - raw) : raw;
    if (32'(mag) > LIMIT) begin
      mag = LIMIT[ANGLE_W-1:0];
    end
    ctl0_nxt        = '0;
    ctl0_nxt.valid  = in_tvalid;
    ctl0_nxt.cosine = in_tuser;
    ctl0_nxt.neg    = raw[ANGLE_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (en) begin
      ctl0_r <= ctl0_nxt;
      mag0_r <= mag;
    end
  end

  // Degrees to radians: partial products against pi/180.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl0_r;
      pplo_r <= PP_W'(mag0_r) * PP_W'(K60[29:0]);
      pphi_r <= PP_W'(mag0_r) * PP_W'(K60[59:30]);
    end
  end

  // Round the radian value to 40 fraction bits; y rides in the sum field.
  assign yfull = ({{(YF_W-PP_W){1'b0}}, pphi_r} << 30) + YF_W'(pplo_r)
               + (YF_W'(1) << (YSH - 1));

  always_comb begin
    ctl2_nxt     = ctl1_r;
    ctl2_nxt.sum = $signed(SUM_W'(yfull[YSH +: MUL_W]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else if (en) begin
      ctl2_r <= ctl2_nxt;
      y_r    <= yfull[YSH +: MUL_W];
    end
  end

  // y squared.
  scd_mul u_mul_sq (
    .clk(clk), .rst_n(rst_n), .en(en),
    .ctl_in(ctl2_r), .a_in(y_r), .b_in(y_r),
    .ctl_out(ctl3), .p_out(y2_p)
  );

  // Term zero: one for cosine, y for sine.
  always_comb begin
    t0 = (ctl3.cosine == OP_COSINE) ? (MUL_W'(1) << SER_FRAC) : MUL_W'(ctl3.sum);
    ctl_t0     = ctl3;
    ctl_t0.y2  = y2_p[Y2_W-1:0];
    ctl_t0.sum = $signed(SUM_W'(t0));
  end

  assign ctl_c[0] = ctl_t0;
  assign t_c[0]   = t0;

  // Series terms one to LAST_TERM.
  for (genvar n = 1; n <= LAST_TERM; n++) begin : g_term
    localparam logic [63:0] DS = 64'((2*n) * (2*n + 1));
    localparam logic [63:0] DC = 64'((2*n - 1) * (2*n));
    localparam logic [63:0] RS = ((64'd1 << SER_FRAC) + DS / 64'd2) / DS;
    localparam logic [63:0] RC = ((64'd1 << SER_FRAC) + DC / 64'd2) / DC;
    localparam logic        SUB = 1'(n % 2);

    scd_term u_term (
      .clk(clk), .rst_n(rst_n), .en(en),
      .rec_sin(RS[MUL_W-1:0]), .rec_cos(RC[MUL_W-1:0]), .sub(SUB),
      .ctl_in(ctl_c[n-1]), .t_in(t_c[n-1]),
      .ctl_out(ctl_c[n]), .t_out(t_c[n])
    );
  end

  // Output: round to Q2.30, saturate, apply sign.
  always_comb begin
    res_neg = ctl_c[LAST_TERM].sum[SUM_W-1];
    q = res_neg ? (SUM_W'(0) - SUM_W'(ctl_c[LAST_TERM].sum))
                : SUM_W'(ctl_c[LAST_TERM].sum);
    om = (q + (SUM_W'(1) << (SER_FRAC - OUT_FRAC - 1))) >> (SER_FRAC - OUT_FRAC);
    if (om > (SUM_W'(1) << OUT_FRAC)) begin
      om_sat = (OUT_FRAC+1)'(1) << OUT_FRAC;
    end else begin
      om_sat = om[OUT_FRAC:0];
    end
    if ((ctl_c[LAST_TERM].cosine != OP_COSINE) && ctl_c[LAST_TERM].neg) begin
      res_neg = !res_neg;
    end
    out_tdata_nxt = res_neg ? (OUT_W'(0) - OUT_W'(om_sat)) : OUT_W'(om_sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= ctl_c[LAST_TERM].valid;
      out_tdata_r  <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== sv/scd_checker.sv =====
// ----------------------------------------------------------------------------
// scd_checker: port-level checks for sine_cosine_degrees
// Watches the result channel for stall behavior, reset and value range, and request readiness.
// ----------------------------------------------------------------------------
module scd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn during stall");

  // A stalled result keeps its value.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed during stall");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // Results stay within plus or minus one in Q2.30.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) <= 32'sd1073741824 &&
                    $signed(out_tdata) >= -32'sd1073741824))
    else $error("result out of range");

  // A ready result side never blocks a new request.
  a_ready: assert property (@(posedge clk) out_tready |-> in_tready)
    else $error("request blocked while result side ready");

endmodule

bind sine_cosine_degrees scd_checker u_scd_checker (
  .clk(clk), .rst_n(rst_n),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// ===== test/sine_cosine_degrees_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_cosine_degrees_check: result predictor and scoreboard
// Watches both stream channels, computes the fixed-point Taylor series value
// of each accepted request and compares it with the oldest pending result.
// ----------------------------------------------------------------------------
module sine_cosine_degrees_check import scd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [17:0] angle_degrees, [23:18] zero
  input  logic        in_tuser,   // [0] opcode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] value
  output int          fail_count,
  output int          pending
);

  logic [31:0] value_queue[$];

  // Product rounded half up by sh bits, kept to 64 bits.
  function automatic logic [63:0] round_mul(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = a * b;
    p = p + (128'd1 << (sh - 1));
    return 64'(p >> sh);
  endfunction

  function automatic logic [63:0] recip40(logic [63:0] d);
    return ((64'd1 << SER_FRAC) + d / 2) / d;
  endfunction

  function automatic logic [31:0] sincos_value(logic [17:0] angle, logic opcode);
    logic        neg, cosine, res_neg;
    logic [63:0] mag, y, y2, t, q, outmag, k;
    logic signed [63:0] sum;
    neg = angle[17];
    cosine = (opcode == OP_COSINE);
    mag = neg ? (64'd1 << ANGLE_W) - {46'd0, angle} : {46'd0, angle};
    if (mag > (64'd360 << ANGLE_FRAC_BITS)) mag = 64'd360 << ANGLE_FRAC_BITS;
    y = round_mul(mag, K60, ANGLE_FRAC_BITS + 60 - SER_FRAC);
    y2 = round_mul(y, y, SER_FRAC);
    t = cosine ? (64'd1 << SER_FRAC) : y;
    sum = $signed(t);
    for (int n = 1; n <= LAST_TERM; n++) begin
      k = cosine ? 64'(2 * n - 1) : 64'(2 * n);
      t = round_mul(t, y2, SER_FRAC);
      t = round_mul(t, recip40(k * (k + 1)), SER_FRAC);
      if (n % 2) sum = sum - $signed(t);
      else sum = sum + $signed(t);
    end
    res_neg = sum < 0;
    q = res_neg ? -sum : sum;
    outmag = (q + (64'd1 << (SER_FRAC - OUT_FRAC - 1))) >> (SER_FRAC - OUT_FRAC);
    if (outmag > (64'd1 << OUT_FRAC)) outmag = 64'd1 << OUT_FRAC;
    if (!cosine && neg) res_neg = !res_neg;
    return res_neg ? -outmag[31:0] : outmag[31:0];
  endfunction

  // Predict on each accepted request, compare on each accepted result.
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        value_queue.push_back(sincos_value(in_tdata[17:0], in_tuser));
      if (out_tvalid && out_tready) begin
        if (value_queue.size() == 0) begin
          $display("%0t: value expected none actual %h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = value_queue.pop_front();
          if (want !== out_tdata) begin
            $display("%0t: value expected %h actual %h", $time, want, out_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= value_queue.size();
  end

endmodule

// ===== test/sine_cosine_degrees_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_cosine_degrees_test: regression for the sine/cosine pipeline
// Sends directed and random angle requests with random gaps and output stalls;
// the checker predicts each value and reports mismatches.
// ----------------------------------------------------------------------------
module sine_cosine_degrees_test;
  import scd_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [17:0] angle_degrees, [23:18] zero
  logic        in_tuser = 1'b0; // [0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [31:0] value
  int          fail_count;
  int          pending;
  int          cycle_count = 0;

  sine_cosine_degrees dut (.*);
  sine_cosine_degrees_check checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver stalls: a random wait before each result is taken.
  initial begin
    int wait_n;
    @(posedge clk iff rst_n);
    forever begin
      wait_n = ($urandom_range(3) == 0) ? 0 : $urandom_range(19);
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk iff out_tvalid);
    end
  end

  // Send one request after an optional random gap; valid stays high through acceptance.
  task automatic send_angle(logic [17:0] angle, logic opcode, bit gaps);
    int wait_n;
    wait_n = gaps ? $urandom_range(19) : 0;
    if (wait_n > 0) begin
      in_tvalid <= 1'b0;
      repeat (wait_n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, angle};
    in_tuser <= opcode;
    @(posedge clk iff in_tready);
  endtask

  initial begin
    logic [17:0] edge_angles[12];
    logic [17:0] a;
    int sel;
    bit gaps;
    edge_angles = '{18'd0, 18'd92160, -18'sd92160, 18'h1FFFF, 18'h20000,
                    18'd23040, -18'sd23040, 18'd46080, 18'd1, 18'h3FFFF,
                    18'd92161, 18'd69120};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: extremes, quadrants and out-of-range clamping, both functions.
    foreach (edge_angles[i]) begin
      send_angle(edge_angles[i], 1'b0, 1'b0);
      send_angle(edge_angles[i], 1'b1, 1'b1);
    end
    // Random: mostly in range, some raw bit patterns, with bursts and gaps.
    for (int i = 0; i < 1050; i++) begin
      if (i % 200 == 0) gaps = 1'($urandom_range(1));
      sel = $urandom_range(9);
      if (sel < 7) a = 18'($signed($urandom_range(184320)) - 92160);
      else a = 18'($urandom);
      send_angle(a, 1'($urandom_range(1)), gaps && ($urandom_range(2) != 0));
    end
    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/scd_pkg.sv
sv/scd_mul.sv
sv/scd_term.sv
sv/sine_cosine_degrees.sv
sv/scd_checker.sv
test/sine_cosine_degrees_check.sv
test/sine_cosine_degrees_test.sv
